// ----- src/sxl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxl_pkg: shared types and codes of the s-expression lexer
// Token kinds, lexer modes, bracket shapes and the records that pass
// between the lexer step logic, the result buffer and the top level.
// ----------------------------------------------------------------------------
package sxl_pkg;

    // lexer mode between characters
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_INT     = 3'd2,
        MODE_MINUS   = 3'd3,
        MODE_SYMBOL  = 3'd4
    } mode_t;

    // token kind codes as they leave the block
    typedef enum logic [3:0] {
        KIND_OPEN    = 4'd0,
        KIND_CLOSE   = 4'd1,
        KIND_QUOTE   = 4'd2,
        KIND_COMMENT = 4'd3,
        KIND_INT     = 4'd4,
        KIND_SYMBOL  = 4'd5,
        KIND_TRUE    = 4'd6,
        KIND_FALSE   = 4'd7,
        KIND_ERROR   = 4'd8,
        KIND_END     = 4'd9
    } kind_t;

    // bracket shapes
    localparam logic [1:0] SHAPE_ROUND  = 2'd0;
    localparam logic [1:0] SHAPE_SQUARE = 2'd1;
    localparam logic [1:0] SHAPE_CURLY  = 2'd2;

    localparam int LINE_W = 24;
    localparam int COL_W  = 24;
    localparam int OFF_W  = 32;
    localparam int LEN_W  = 16;
    localparam int KW_W   = 4;

    // result buffer depth and its full count
    localparam int          BUF_DEPTH = 2;
    localparam logic [1:0]  BUF_FULL  = 2'd2;

    // register addresses (word index, paddr[2])
    localparam logic REG_DROP_COMMENTS = 1'b0;
    localparam logic REG_FIRST_LINE    = 1'b1;

    // one token as it sits in the result buffer
    typedef struct packed {
        kind_t              kind;
        logic [1:0]         shape;
        logic [LINE_W-1:0]  line;
        logic [COL_W-1:0]   col;
        logic [OFF_W-1:0]   offset;
        logic [LEN_W-1:0]   length;
        logic               last;
    } result_t;

    // lexer state carried from one character to the next
    typedef struct packed {
        mode_t              mode;
        logic [LINE_W-1:0]  cur_line;
        logic [COL_W-1:0]   cur_col;
        logic [OFF_W-1:0]   char_offset;
        logic [LINE_W-1:0]  tok_line;
        logic [COL_W-1:0]   tok_col;
        logic [OFF_W-1:0]   tok_offset;
        logic [LEN_W-1:0]   pend_len;
        logic [KW_W-1:0]    kw;
    } lex_state_t;

endpackage

// ----- src/sxl_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxl_step: next-state and token logic for one character
// Pure combinational step of the lexer: from the current state and one
// character (or end of input) it gives the next state and up to two tokens,
// packed so that the first valid token is always in res0.
// ----------------------------------------------------------------------------
module sxl_step (
    input  sxl_pkg::lex_state_t  state_in,
    input  logic [7:0]           char_byte,
    input  logic                 end_of_input,
    input  logic                 drop_comments,
    output sxl_pkg::lex_state_t  state_out,
    output logic [1:0]           res_cnt,
    output sxl_pkg::result_t     res0,
    output sxl_pkg::result_t     res1
);

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    // keyword prefix tracking: t r u e / f a l s e
    localparam logic [3:0] KW_NONE  = 4'd0;
    localparam logic [3:0] KW_T     = 4'd1;
    localparam logic [3:0] KW_TR    = 4'd2;
    localparam logic [3:0] KW_TRU   = 4'd3;
    localparam logic [3:0] KW_TRUE  = 4'd4;
    localparam logic [3:0] KW_F     = 4'd5;
    localparam logic [3:0] KW_FA    = 4'd6;
    localparam logic [3:0] KW_FAL   = 4'd7;
    localparam logic [3:0] KW_FALS  = 4'd8;
    localparam logic [3:0] KW_FALSE = 4'd9;

    function automatic logic [23:0] sat24_inc(input logic [23:0] v);
        return (v == 24'hFFFFFF) ? v : v + 24'd1;
    endfunction

    function automatic logic [15:0] sat16_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [3:0] kw_next(input logic [3:0] k, input logic [7:0] c);
        logic [3:0] r;
        r = KW_NONE;
        if (k == KW_T && c == "r") r = KW_TR;
        if (k == KW_TR && c == "u") r = KW_TRU;
        if (k == KW_TRU && c == "e") r = KW_TRUE;
        if (k == KW_F && c == "a") r = KW_FA;
        if (k == KW_FA && c == "l") r = KW_FAL;
        if (k == KW_FAL && c == "s") r = KW_FALS;
        if (k == KW_FALS && c == "e") r = KW_FALSE;
        return r;
    endfunction

    logic                 is_digit;
    logic                 is_ident;
    logic                 is_delim;
    sxl_pkg::result_t     flush_res;
    logic                 flush_vld;
    sxl_pkg::result_t     idle_res;
    logic                 idle_vld;
    sxl_pkg::lex_state_t  idle_state;

    // character classes
    always_comb begin
        is_digit = char_byte inside {["0":"9"]};
        is_ident = char_byte inside {["A":"Z"], ["a":"z"], ["0":"9"], "_", "-", "?",
                                     "!", "@", "&", "*", "+", "/", "$", "%", "^", "~"};
        is_delim = char_byte inside {CH_SPACE, CH_TAB, CH_NEWLINE, CH_RPAREN,
                                     CH_RBRACK, CH_RBRACE};
    end

    // token that a pending run gives when it is closed
    always_comb begin
        flush_res        = '0;
        flush_res.kind   = sxl_pkg::KIND_SYMBOL;
        flush_res.shape  = sxl_pkg::SHAPE_ROUND;
        flush_res.line   = state_in.tok_line;
        flush_res.col    = state_in.tok_col;
        flush_res.offset = state_in.tok_offset;
        flush_res.length = state_in.pend_len;
        flush_res.last   = 1'b0;
        flush_vld        = 1'b0;
        case (state_in.mode)
            sxl_pkg::MODE_COMMENT: begin
                flush_res.kind = sxl_pkg::KIND_COMMENT;
                flush_vld      = !drop_comments;
            end
            sxl_pkg::MODE_INT: begin
                flush_res.kind = sxl_pkg::KIND_INT;
                flush_vld      = 1'b1;
            end
            sxl_pkg::MODE_MINUS: begin
                flush_vld = 1'b1;
            end
            sxl_pkg::MODE_SYMBOL: begin
                if (state_in.kw == KW_TRUE) begin
                    flush_res.kind = sxl_pkg::KIND_TRUE;
                end else if (state_in.kw == KW_FALSE) begin
                    flush_res.kind = sxl_pkg::KIND_FALSE;
                end
                flush_vld = 1'b1;
            end
            default: begin
                flush_vld = 1'b0;
            end
        endcase
    end

    // a character seen between tokens
    always_comb begin
        idle_state             = state_in;
        idle_state.mode        = sxl_pkg::MODE_IDLE;
        idle_state.kw          = KW_NONE;
        idle_state.cur_col     = sat24_inc(state_in.cur_col);
        idle_state.char_offset = state_in.char_offset + 32'd1;
        idle_res               = '0;
        idle_res.kind          = sxl_pkg::KIND_ERROR;
        idle_res.shape         = sxl_pkg::SHAPE_ROUND;
        idle_res.line          = state_in.cur_line;
        idle_res.col           = state_in.cur_col;
        idle_res.offset        = state_in.char_offset;
        idle_res.length        = 16'd1;
        idle_res.last          = 1'b0;
        idle_vld               = 1'b0;
        if (char_byte == CH_NEWLINE) begin
            idle_state.cur_line = sat24_inc(state_in.cur_line);
            idle_state.cur_col  = '0;
        end else if (char_byte == CH_SPACE || char_byte == CH_TAB) begin
            idle_vld = 1'b0;
        end else if (char_byte == CH_LPAREN) begin
            idle_res.kind = sxl_pkg::KIND_OPEN;
            idle_vld      = 1'b1;
        end else if (char_byte == CH_LBRACK) begin
            idle_res.kind  = sxl_pkg::KIND_OPEN;
            idle_res.shape = sxl_pkg::SHAPE_SQUARE;
            idle_vld       = 1'b1;
        end else if (char_byte == CH_LBRACE) begin
            idle_res.kind  = sxl_pkg::KIND_OPEN;
            idle_res.shape = sxl_pkg::SHAPE_CURLY;
            idle_vld       = 1'b1;
        end else if (char_byte == CH_RPAREN) begin
            idle_res.kind = sxl_pkg::KIND_CLOSE;
            idle_vld      = 1'b1;
        end else if (char_byte == CH_RBRACK) begin
            idle_res.kind  = sxl_pkg::KIND_CLOSE;
            idle_res.shape = sxl_pkg::SHAPE_SQUARE;
            idle_vld       = 1'b1;
        end else if (char_byte == CH_RBRACE) begin
            idle_res.kind  = sxl_pkg::KIND_CLOSE;
            idle_res.shape = sxl_pkg::SHAPE_CURLY;
            idle_vld       = 1'b1;
        end else if (char_byte == CH_QUOTE) begin
            idle_res.kind = sxl_pkg::KIND_QUOTE;
            idle_vld      = 1'b1;
        end else if (char_byte == CH_SEMI || is_digit || is_ident) begin
            // a multi-character token opens here
            idle_state.tok_line   = state_in.cur_line;
            idle_state.tok_col    = state_in.cur_col;
            idle_state.tok_offset = state_in.char_offset;
            idle_state.pend_len   = 16'd1;
            if (char_byte == CH_SEMI) begin
                idle_state.mode = sxl_pkg::MODE_COMMENT;
            end else if (is_digit) begin
                idle_state.mode = sxl_pkg::MODE_INT;
            end else if (char_byte == CH_MINUS) begin
                idle_state.mode = sxl_pkg::MODE_MINUS;
            end else begin
                idle_state.mode = sxl_pkg::MODE_SYMBOL;
                if (char_byte == "t") begin
                    idle_state.kw = KW_T;
                end else if (char_byte == "f") begin
                    idle_state.kw = KW_F;
                end
            end
        end else begin
            // any other byte is a one-character error
            idle_vld = 1'b1;
        end
    end

    sxl_pkg::result_t     second_res;
    logic                 second_vld;
    logic                 use_flush;
    sxl_pkg::lex_state_t  nxt;

    // choose the path for this character
    always_comb begin
        nxt        = state_in;
        use_flush  = 1'b0;
        second_res = idle_res;
        second_vld = 1'b0;
        if (end_of_input) begin
            use_flush         = 1'b1;
            nxt.mode          = sxl_pkg::MODE_IDLE;
            nxt.kw            = KW_NONE;
            second_res        = '0;
            second_res.kind   = sxl_pkg::KIND_END;
            second_res.shape  = sxl_pkg::SHAPE_ROUND;
            second_res.line   = state_in.cur_line;
            second_res.col    = state_in.cur_col;
            second_res.offset = state_in.char_offset;
            second_res.length = '0;
            second_vld        = 1'b1;
        end else if (state_in.mode == sxl_pkg::MODE_COMMENT) begin
            if (char_byte == CH_NEWLINE) begin
                use_flush  = 1'b1;
                nxt        = idle_state;
                second_vld = idle_vld;
            end else begin
                nxt.pend_len    = sat16_inc(state_in.pend_len);
                nxt.cur_col     = sat24_inc(state_in.cur_col);
                nxt.char_offset = state_in.char_offset + 32'd1;
            end
        end else if (state_in.mode == sxl_pkg::MODE_INT
                     || (state_in.mode == sxl_pkg::MODE_MINUS && is_digit)) begin
            if (is_digit) begin
                nxt.mode        = sxl_pkg::MODE_INT;
                nxt.pend_len    = sat16_inc(state_in.pend_len);
                nxt.cur_col     = sat24_inc(state_in.cur_col);
                nxt.char_offset = state_in.char_offset + 32'd1;
            end else if (is_delim) begin
                use_flush  = 1'b1;
                nxt        = idle_state;
                second_vld = idle_vld;
            end else begin
                // digit run ended by a non-delimiter: error takes in the char
                second_res        = '0;
                second_res.kind   = sxl_pkg::KIND_ERROR;
                second_res.shape  = sxl_pkg::SHAPE_ROUND;
                second_res.line   = state_in.tok_line;
                second_res.col    = state_in.tok_col;
                second_res.offset = state_in.tok_offset;
                second_res.length = sat16_inc(state_in.pend_len);
                second_vld        = 1'b1;
                nxt.mode          = sxl_pkg::MODE_IDLE;
                nxt.kw            = KW_NONE;
                nxt.cur_col       = sat24_inc(state_in.cur_col);
                nxt.char_offset   = state_in.char_offset + 32'd1;
            end
        end else if (state_in.mode == sxl_pkg::MODE_MINUS
                     || state_in.mode == sxl_pkg::MODE_SYMBOL) begin
            if (is_ident) begin
                nxt.kw          = (state_in.mode == sxl_pkg::MODE_SYMBOL)
                                  ? kw_next(state_in.kw, char_byte) : KW_NONE;
                nxt.mode        = sxl_pkg::MODE_SYMBOL;
                nxt.pend_len    = sat16_inc(state_in.pend_len);
                nxt.cur_col     = sat24_inc(state_in.cur_col);
                nxt.char_offset = state_in.char_offset + 32'd1;
            end else begin
                use_flush  = 1'b1;
                nxt        = idle_state;
                second_vld = idle_vld;
            end
        end else begin
            nxt        = idle_state;
            second_vld = idle_vld;
        end
    end

    // pack tokens so the first one sits in res0, mark the final one
    always_comb begin
        state_out = nxt;
        res0      = second_res;
        res1      = second_res;
        res_cnt   = {1'b0, second_vld};
        if (use_flush && flush_vld) begin
            res0    = flush_res;
            res_cnt = second_vld ? 2'd2 : 2'd1;
        end
        res0.last = (res_cnt == 2'd1);
        res1.last = 1'b1;
    end

endmodule

// ----- src/sxl_out_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxl_out_buf: two-entry result buffer
// Takes up to two tokens per cycle from the lexer step and hands one token
// per cycle to the ready result channel. The writer only pushes what fits.
// ----------------------------------------------------------------------------
module sxl_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        push_cnt,
    input  sxl_pkg::result_t  push0,
    input  sxl_pkg::result_t  push1,
    input  logic              pop,
    output sxl_pkg::result_t  head,
    output logic              head_vld,
    output logic [1:0]        count
);

    sxl_pkg::result_t  slot_reg [sxl_pkg::BUF_DEPTH];
    sxl_pkg::result_t  slot_next [sxl_pkg::BUF_DEPTH];
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    logic [1:0]        kept;
    sxl_pkg::result_t  keep0;

    // drop the head on a pop, then append the new tokens behind what is left
    always_comb begin
        kept     = cnt_reg - {1'b0, pop};
        keep0    = pop ? slot_reg[1] : slot_reg[0];
        cnt_next = kept + push_cnt;
        slot_next[0] = (kept != 2'd0) ? keep0 : push0;
        if (kept == 2'd2) begin
            slot_next[1] = slot_reg[1];
        end else if (kept == 2'd1) begin
            slot_next[1] = push0;
        end else begin
            slot_next[1] = push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // payload slots need no reset
    always_ff @(posedge aclk) begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

    assign head     = slot_reg[0];
    assign head_vld = (cnt_reg != 2'd0);
    assign count    = cnt_reg;

endmodule

// ----- src/s_expression_lexer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s_expression_lexer_core: streaming lexer for a bracketed list language
// One source character per request on the s_ channel; tokens with their
//   start line, column, offset and length leave one per transfer on the m_
// channel. Two registers on an APB-style port: drop_comments at 0x0 and
// first_line at 0x4.
// ----------------------------------------------------------------------------
// Usage:
//   A request is accepted on s_valid & s_ready. It lands in an input
//   register; the lexer step runs on it once its tokens fit, and they
//   (zero, one or two) go into a two-entry result buffer, from which m_
//   tokens are offered. m_last_of_run marks the last token of one request.
//   Throughput: one request per cycle while each request yields at most one
//   token and the receiver keeps up; a request that closes a pending token
//   and emits its own holds the input until both tokens fit, since the
//   step runs only when all its tokens fit in the slots free before this
//   cycle's drain, and the result port drains one token per cycle.
//   s_ready depends only on internal registers. When the receiver stalls,
//   the buffer fills, the input register holds its request, and s_ready
//   falls; nothing is dropped.
//   Reset (aresetn low, synchronous) empties the input register and buffer,
//   puts the lexer between tokens at line first_line, column 0, offset 0,
//   and sets drop_comments to 0 and first_line to 1.
// ----------------------------------------------------------------------------
module s_expression_lexer_core (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // character requests
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [7:0]   s_char_byte,
    input  logic         s_end_of_input,
    // token requests
    output logic         m_valid,
    input  logic         m_ready,
    output logic [3:0]   m_token_kind,
    output logic [1:0]   m_bracket_shape,
    output logic [23:0]  m_start_line,
    output logic [23:0]  m_start_col,
    output logic [31:0]  m_start_offset,
    output logic [15:0]  m_token_length,
    output logic         m_last_of_run
);

    // lexer state after reset: between tokens, line 1, everything else zero
    localparam sxl_pkg::lex_state_t STATE_RESET = '{
        mode:     sxl_pkg::MODE_IDLE,
        cur_line: 24'd1,
        default:  '0
    };

    logic                 drop_comments_reg;
    logic                 first_line_reg;
    logic                 cfg_wr;

    logic                 in_vld_reg;
    logic [7:0]           in_char_reg;
    logic                 in_eoi_reg;

    sxl_pkg::lex_state_t  state_reg;
    sxl_pkg::lex_state_t  state_next;
    sxl_pkg::lex_state_t  step_state;
    logic [1:0]           step_cnt;
    sxl_pkg::result_t     step_res0;
    logic                 fire;
    logic [1:0]           push_cnt;
    sxl_pkg::result_t     step_res1;
    sxl_pkg::result_t     head;
    logic                 head_vld;
    logic [1:0]           buf_count;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        case (paddr[2])
            sxl_pkg::REG_DROP_COMMENTS: prdata[0] = drop_comments_reg;
            sxl_pkg::REG_FIRST_LINE:    prdata[0] = first_line_reg;
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drop_comments_reg <= 1'b0;
            first_line_reg    <= 1'b1;
        end else if (cfg_wr) begin
            if (paddr[2] == sxl_pkg::REG_DROP_COMMENTS) begin
                drop_comments_reg <= pwdata[0];
            end else begin
                first_line_reg <= pwdata[0];
            end
        end
    end

    // lexer step on the registered character
    sxl_step u_step (
        .state_in      (state_reg),
        .char_byte     (in_char_reg),
        .end_of_input  (in_eoi_reg),
        .drop_comments (drop_comments_reg),
        .state_out     (step_state),
        .res_cnt       (step_cnt),
        .res0          (step_res0),
        .res1          (step_res1)
    );

    // run the step only when all its tokens fit in the buffer
    assign fire     = in_vld_reg && (step_cnt <= (sxl_pkg::BUF_FULL - buf_count));
    assign push_cnt = fire ? step_cnt : 2'd0;
    assign s_ready  = !in_vld_reg || fire;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_byte;
            in_eoi_reg  <= s_end_of_input;
        end
    end

    // lexer state; a first_line write reloads the line before any character
    always_comb begin
        state_next = state_reg;
        if (fire) begin
            state_next = step_state;
        end
        if (cfg_wr && paddr[2] == sxl_pkg::REG_FIRST_LINE
            && state_reg.char_offset == '0) begin
            state_next.cur_line = {{(sxl_pkg::LINE_W-1){1'b0}}, pwdata[0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else begin
            state_reg <= state_next;
        end
    end

    // result buffer
    sxl_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (push_cnt),
        .push0    (step_res0),
        .push1    (step_res1),
        .pop      (m_ready && head_vld),
        .head     (head),
        .head_vld (head_vld),
        .count    (buf_count)
    );

    assign m_valid         = head_vld;
    assign m_token_kind    = head.kind;
    assign m_bracket_shape = head.shape;
    assign m_start_line    = head.line;
    assign m_start_col     = head.col;
    assign m_start_offset  = head.offset;
    assign m_token_length  = head.length;
    assign m_last_of_run   = head.last;

endmodule
